// ===== rtl/elx_pkg.sv =====
// Shared types, codes and helpers for the expression lexer.
`timescale 1ns / 1ps
`default_nettype none
package elx_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int POS_W    = $clog2(MAX_LEN + 1);
    localparam int EXT_W    = (POS_W + 1 > 13) ? POS_W + 1 : 13;

    // token kinds
    localparam logic [2:0] K_NUM      = 3'd0;
    localparam logic [2:0] K_VAR      = 3'd1;
    localparam logic [2:0] K_SIGN     = 3'd2;
    localparam logic [2:0] K_END      = 3'd3;
    localparam logic [2:0] K_BADFIRST = 3'd4;
    localparam logic [2:0] K_UNTOK    = 3'd5;
    localparam logic [2:0] K_LONG     = 3'd6;

    // sign codes
    localparam logic [2:0] S_PLUS   = 3'd0;
    localparam logic [2:0] S_MINUS  = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_MOD    = 3'd4;
    localparam logic [2:0] S_LPAR   = 3'd5;
    localparam logic [2:0] S_RPAR   = 3'd6;
    localparam logic [2:0] S_ASSIGN = 3'd7;

    // lexer modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_NUMZ  = 3'd1;
    localparam logic [2:0] MODE_NUM   = 3'd2;
    localparam logic [2:0] MODE_VAR   = 3'd3;
    localparam logic [2:0] MODE_COLON = 3'd4;

    // characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  sign;
        logic [12:0] start_pos;
        logic [12:0] end_pos;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [2:0]       mode;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] tstart;
        logic             first_seen;
    } lex_state_t;

    // position (one bit of headroom) down to the 13-bit output field
    function automatic logic [12:0] pos_out(input logic [POS_W:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return w[12:0];
    endfunction

    function automatic result_t mk_res(input logic [2:0] kind, input logic [2:0] sign,
                                       input logic [POS_W:0] s, input logic [POS_W:0] e,
                                       input logic last);
        result_t r;
        r.kind      = kind;
        r.sign      = sign;
        r.start_pos = pos_out(s);
        r.end_pos   = pos_out(e);
        r.last      = last;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/elx_step.sv =====
// Lexer next-state and token logic for one character.
`timescale 1ns / 1ps
`default_nettype none
module elx_step (
    input  wire logic [7:0]          ch,
    input  wire elx_pkg::lex_state_t cur,
    output elx_pkg::lex_state_t      nxt,
    output elx_pkg::result_t         res0,
    output elx_pkg::result_t         res1,
    output logic [1:0]               res_cnt
);
    import elx_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);
    localparam logic [POS_W:0]   ZERO_X  = '0;

    logic             term, is_dig, is_aln, is_blank, sg_ok;
    logic [2:0]       sg_code;
    logic [POS_W:0]   p_x, p1_x, ts_x;
    logic [POS_W-1:0] p1;
    logic             pa_vld, pb_vld, done, clr;
    result_t          pa, pb;

    always_comb begin
        term     = (ch == CH_NL) || (ch == CH_NUL);
        is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_aln   = is_dig || ((ch >= CH_LA) && (ch <= CH_LZ)) ||
                   ((ch >= CH_UA) && (ch <= CH_UZ));
        is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
        sg_ok    = 1'b1;
        case (ch)
            CH_PLUS:  sg_code = S_PLUS;
            CH_MINUS: sg_code = S_MINUS;
            CH_STAR:  sg_code = S_MUL;
            CH_SLASH: sg_code = S_DIV;
            CH_PCT:   sg_code = S_MOD;
            CH_LPAR:  sg_code = S_LPAR;
            CH_RPAR:  sg_code = S_RPAR;
            default: begin
                sg_code = S_PLUS;
                sg_ok   = 1'b0;
            end
        endcase
    end

    always_comb begin
        p_x    = {1'b0, cur.pos};
        p1_x   = p_x + 1'b1;
        p1     = p1_x[POS_W-1:0];   // only stored when pos < MAX_LEN
        ts_x   = {1'b0, cur.tstart};
        nxt    = cur;
        pa     = '0;
        pb     = '0;
        pa_vld = 1'b0;
        pb_vld = 1'b0;
        done   = 1'b0;
        clr    = 1'b0;

        if (!term && (cur.pos >= MAX_POS)) begin
            pa     = mk_res(K_LONG, S_PLUS, p_x, ZERO_X, 1'b1);
            pa_vld = 1'b1;
            clr    = 1'b1;
            done   = 1'b1;
        end else begin
            case (cur.mode)
                MODE_COLON: begin
                    pa_vld = 1'b1;
                    done   = 1'b1;
                    if (ch == CH_EQ) begin
                        pa       = mk_res(K_SIGN, S_ASSIGN, ts_x, p1_x, 1'b0);
                        nxt.mode = MODE_IDLE;
                        nxt.pos  = p1;
                    end else begin
                        // lone colon: following byte is swallowed too
                        pa  = mk_res(K_UNTOK, S_PLUS, ts_x, ZERO_X, 1'b1);
                        clr = 1'b1;
                    end
                end
                MODE_NUMZ: begin
                    if (ch == CH_ZERO) begin
                        nxt.tstart = p1;
                        nxt.pos    = p1;
                        done       = 1'b1;
                    end else if (is_dig) begin
                        nxt.mode = MODE_NUM;
                        nxt.pos  = p1;
                        done     = 1'b1;
                    end else begin
                        pa       = mk_res(K_NUM, S_PLUS, ts_x, p_x, 1'b0);
                        pa_vld   = 1'b1;
                        nxt.mode = MODE_IDLE;
                    end
                end
                MODE_NUM: begin
                    if (is_dig) begin
                        nxt.pos = p1;
                        done    = 1'b1;
                    end else begin
                        pa       = mk_res(K_NUM, S_PLUS, ts_x, p_x, 1'b0);
                        pa_vld   = 1'b1;
                        nxt.mode = MODE_IDLE;
                    end
                end
                MODE_VAR: begin
                    if (is_aln) begin
                        nxt.pos = p1;
                        done    = 1'b1;
                    end else begin
                        pa       = mk_res(K_VAR, S_PLUS, ts_x, p_x, 1'b0);
                        pa_vld   = 1'b1;
                        nxt.mode = MODE_IDLE;
                    end
                end
                default: nxt.mode = MODE_IDLE;
            endcase
        end

        if (!done) begin
            if (is_blank) begin
                nxt.pos = p1;
            end else if (!cur.first_seen && !is_dig && (ch != CH_LPAR) &&
                         (ch != CH_DOLLAR)) begin
                pb     = mk_res(K_BADFIRST, S_PLUS, p_x, ZERO_X, 1'b1);
                pb_vld = 1'b1;
                clr    = 1'b1;
            end else if (term) begin
                pb     = mk_res(K_END, S_PLUS, p_x, p1_x, 1'b1);
                pb_vld = 1'b1;
                clr    = 1'b1;
            end else begin
                if (sg_ok) begin
                    pb     = mk_res(K_SIGN, sg_code, p_x, p1_x, 1'b0);
                    pb_vld = 1'b1;
                end else if (ch == CH_ZERO) begin
                    nxt.mode   = MODE_NUMZ;
                    nxt.tstart = p1;
                end else if (is_dig) begin
                    nxt.mode   = MODE_NUM;
                    nxt.tstart = cur.pos;
                end else if (ch == CH_DOLLAR) begin
                    nxt.mode   = MODE_VAR;
                    nxt.tstart = cur.pos;
                end else if (ch == CH_COLON) begin
                    nxt.mode   = MODE_COLON;
                    nxt.tstart = cur.pos;
                end else begin
                    pb     = mk_res(K_UNTOK, S_PLUS, p_x, ZERO_X, 1'b1);
                    pb_vld = 1'b1;
                    clr    = 1'b1;
                end
                nxt.first_seen = 1'b1;
                nxt.pos        = p1;
            end
        end

        if (clr) begin
            nxt.mode       = MODE_IDLE;
            nxt.pos        = '0;
            nxt.tstart     = '0;
            nxt.first_seen = 1'b0;
        end
    end

    // pending token goes first, new token after it
    assign res0    = pa_vld ? pa : pb;
    assign res1    = pb;
    assign res_cnt = {1'b0, pa_vld} + {1'b0, pb_vld};

endmodule
`default_nettype wire

// ===== rtl/elx_fifo.sv =====
// Four-entry result queue, up to two writes and one read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module elx_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [1:0]       push_cnt,
    input  wire elx_pkg::result_t wdata0,
    input  wire elx_pkg::result_t wdata1,
    output logic                  room2,
    output logic                  out_valid,
    output elx_pkg::result_t      out_data,
    input  wire logic             pop
);
    import elx_pkg::*;

    localparam int DEPTH = 4;

    result_t    mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       do_pop;
    logic [1:0] wr_ptr1;

    assign room2     = (count_reg <= 3'(DEPTH - 2));
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;
    assign wr_ptr1   = wr_ptr_reg + 2'd1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b00, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= wdata0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr1] <= wdata1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/expression_lexer_core.sv =====
// Top level of the streaming calculator-expression lexer.
// Path: a character accepted from s_ sits in the input register; once the result queue
//   has room for two tokens it is lexed, and its tokens are written to the queue, whose
//   head is on m_ from then on.
// Throughput: one character per cycle, as long as the result queue keeps room
//   for two tokens (a character can close a pending token and emit its own).
// Reset: aresetn low clears the lexer state to position 0, first-token mode,
//   and empties the input register and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module expression_lexer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_character,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_token_kind,
    output logic [2:0]       m_sign_code,
    output logic [12:0]      m_start_pos,
    output logic [12:0]      m_end_pos,
    output logic             m_last
);
    import elx_pkg::*;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_char_reg;

    // lexer state
    lex_state_t st_reg, st_next;

    result_t    res0, res1, head;
    logic [1:0] res_cnt, push_cnt;
    logic       room2, fire;

    // A held character is lexed once the queue can take both possible tokens.
    assign fire    = in_vld_reg && room2;
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_character;
        end
    end

    elx_step u_step (
        .ch      (in_char_reg),
        .cur     (st_reg),
        .nxt     (st_next),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    // state only moves when the character is actually consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.mode       <= MODE_IDLE;
            st_reg.pos        <= '0;
            st_reg.tstart     <= '0;
            st_reg.first_seen <= 1'b0;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

    assign push_cnt = fire ? res_cnt : 2'd0;

    elx_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .wdata0    (res0),
        .wdata1    (res1),
        .room2     (room2),
        .out_valid (m_valid),
        .out_data  (head),
        .pop       (m_ready)
    );

    // result fields straight from the queue head
    assign m_token_kind = head.kind;
    assign m_sign_code  = head.sign;
    assign m_start_pos  = head.start_pos;
    assign m_end_pos    = head.end_pos;
    assign m_last       = head.last;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming expression lexer core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import elx_pkg::*;

    // sign_code carried by every token that is not a sign
    localparam logic [2:0] NO_SIGN = 3'd0;
    // random part: non-blank requests to send, and where the quiet tail starts
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_TAIL   = 1400;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_character;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_token_kind;
    logic [2:0]  m_sign_code;
    logic [12:0] m_start_pos;
    logic [12:0] m_end_pos;
    logic        m_last;

    expression_lexer_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_character  (s_character),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_token_kind (m_token_kind),
        .m_sign_code  (m_sign_code),
        .m_start_pos  (m_start_pos),
        .m_end_pos    (m_end_pos),
        .m_last       (m_last)
    );

    always #5 aclk = ~aclk;

    // Tokens the lexer owes us, oldest first.
    result_t     pending_tokens[$];
    int          mismatch_count = 0;

    // Shadow lexer state, updated once per accepted request.
    logic [2:0]  lex_mode;
    int unsigned lex_pos;
    int unsigned lex_start;
    bit          lex_first;

    // Idle/stall enables for the two sides.
    bit          idle_on  = 1'b1;
    bit          stall_on = 1'b1;

    // Bytes of the expression being built for the random part.
    logic [7:0]  text_q[$];

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic bit is_digit_ch(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic bit is_alnum_ch(input logic [7:0] ch);
        return is_digit_ch(ch) || (ch >= CH_LA && ch <= CH_LZ) || (ch >= CH_UA && ch <= CH_UZ);
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    task automatic restart_expression();
        lex_mode  = MODE_IDLE;
        lex_pos   = 0;
        lex_start = 0;
        lex_first = 1'b0;
    endtask

    task automatic push_token(input logic [2:0] kind, input logic [2:0] sign,
                              input int unsigned s, input int unsigned e, input bit last);
        result_t r;
        r.kind      = kind;
        r.sign      = sign;
        r.start_pos = 13'(s);
        r.end_pos   = 13'(e);
        r.last      = last;
        pending_tokens.push_back(r);
    endtask

    // Work out the tokens closed by one accepted character (at most two).
    task automatic predict_tokens(input logic [7:0] ch);
        int unsigned p;
        bit          term;
        bit          is_sign;
        logic [2:0]  sg;
        p    = lex_pos;
        term = (ch == CH_NL) || (ch == CH_NUL);

        // past the length limit anything but a terminator kills the expression
        if (!term && p >= MAX_LEN) begin
            push_token(K_LONG, NO_SIGN, p, 0, 1'b1);
            restart_expression();
            return;
        end

        // first let the character close or extend the pending token
        case (lex_mode)
            MODE_COLON: begin
                if (ch == CH_EQ) begin
                    push_token(K_SIGN, S_ASSIGN, lex_start, p + 1, 1'b0);
                    lex_mode = MODE_IDLE;
                    lex_pos  = p + 1;
                end else begin
                    // lone colon: the follower is swallowed with it
                    push_token(K_UNTOK, NO_SIGN, lex_start, 0, 1'b1);
                    restart_expression();
                end
                return;
            end
            MODE_NUMZ: begin
                if (ch == CH_ZERO) begin
                    // another leading zero: span start slides right
                    lex_start = p + 1;
                    lex_pos   = p + 1;
                    return;
                end
                if (is_digit_ch(ch)) begin
                    lex_mode = MODE_NUM;
                    lex_pos  = p + 1;
                    return;
                end
                push_token(K_NUM, NO_SIGN, lex_start, p, 1'b0);
                lex_mode = MODE_IDLE;
            end
            MODE_NUM: begin
                if (is_digit_ch(ch)) begin
                    lex_pos = p + 1;
                    return;
                end
                push_token(K_NUM, NO_SIGN, lex_start, p, 1'b0);
                lex_mode = MODE_IDLE;
            end
            MODE_VAR: begin
                if (is_alnum_ch(ch)) begin
                    lex_pos = p + 1;
                    return;
                end
                push_token(K_VAR, NO_SIGN, lex_start, p, 1'b0);
                lex_mode = MODE_IDLE;
            end
            default: lex_mode = MODE_IDLE;
        endcase

        if (ch == CH_SPACE || ch == CH_TAB) begin
            lex_pos = p + 1;
            return;
        end
        if (!lex_first && !is_digit_ch(ch) && ch != CH_LPAR && ch != CH_DOLLAR) begin
            push_token(K_BADFIRST, NO_SIGN, p, 0, 1'b1);
            restart_expression();
            return;
        end
        if (term) begin
            push_token(K_END, NO_SIGN, p, p + 1, 1'b1);
            restart_expression();
            return;
        end

        is_sign = 1'b1;
        sg      = NO_SIGN;
        case (ch)
            CH_PLUS:  sg = S_PLUS;
            CH_MINUS: sg = S_MINUS;
            CH_STAR:  sg = S_MUL;
            CH_SLASH: sg = S_DIV;
            CH_PCT:   sg = S_MOD;
            CH_LPAR:  sg = S_LPAR;
            CH_RPAR:  sg = S_RPAR;
            default:  is_sign = 1'b0;
        endcase

        if (is_sign) begin
            push_token(K_SIGN, sg, p, p + 1, 1'b0);
        end else if (ch == CH_ZERO) begin
            lex_mode  = MODE_NUMZ;
            lex_start = p + 1;
        end else if (is_digit_ch(ch)) begin
            lex_mode  = MODE_NUM;
            lex_start = p;
        end else if (ch == CH_DOLLAR) begin
            lex_mode  = MODE_VAR;
            lex_start = p;
        end else if (ch == CH_COLON) begin
            lex_mode  = MODE_COLON;
            lex_start = p;
        end else begin
            push_token(K_UNTOK, NO_SIGN, p, 0, 1'b1);
            restart_expression();
            return;
        end
        lex_first = 1'b1;
        lex_pos   = p + 1;
    endtask

    // ------------------------------------------------------------------
    // Request side: drive at falling edge, handshake seen at rising edge
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] ch);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            s_character = 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 19) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     = 1'b1;
        s_character = ch;
        do @(posedge aclk); while (!s_ready);
        predict_tokens(ch);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
    endtask

    // Hold off new requests until every owed token has come back.
    task automatic drain_tokens();
        @(negedge aclk);
        s_valid = 1'b0;
        wait (pending_tokens.size() == 0);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts on m_ready
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_on && $urandom_range(0, 11) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // Compare every accepted token with the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d sign %0d %0d..%0d last %0b",
                                          m_token_kind, m_sign_code, m_start_pos, m_end_pos,
                                          m_last));
            end else begin
                want = pending_tokens.pop_front();
                if (m_token_kind !== want.kind)
                    report_mismatch($sformatf("token_kind %0d, want %0d",
                                              m_token_kind, want.kind));
                if (m_sign_code !== want.sign)
                    report_mismatch($sformatf("sign_code %0d, want %0d",
                                              m_sign_code, want.sign));
                if (m_start_pos !== want.start_pos)
                    report_mismatch($sformatf("start_pos %0d, want %0d",
                                              m_start_pos, want.start_pos));
                if (m_end_pos !== want.end_pos)
                    report_mismatch($sformatf("end_pos %0d, want %0d",
                                              m_end_pos, want.end_pos));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random expression builder
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_alnum();
        int unsigned r;
        r = $urandom_range(0, 61);
        if (r < 10) return CH_ZERO + 8'(r);
        if (r < 36) return CH_UA + 8'(r - 10);
        return CH_LA + 8'(r - 36);
    endfunction

    function automatic logic [7:0] rand_sign_char();
        case ($urandom_range(0, 6))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_PCT;
            5:       return CH_LPAR;
            default: return CH_RPAR;
        endcase
    endfunction

    task automatic add_number();
        int unsigned zeros;
        int unsigned digits;
        zeros  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        digits = $urandom_range(0, 4);
        if (zeros == 0 && digits == 0) digits = 1;
        repeat (zeros) text_q.push_back(CH_ZERO);
        repeat (digits) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_variable();
        text_q.push_back(CH_DOLLAR);
        repeat ($urandom_range(0, 5)) text_q.push_back(rand_alnum());
    endtask

    task automatic add_blanks();
        repeat ($urandom_range(1, 2))
            text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    // Mostly well-formed expressions; some are only random bytes, and a share get a corrupted
    // byte, a lone colon, or lose their terminator (and run into the next expression).
    task automatic build_expression();
        int unsigned idx;
        text_q.delete();
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 5) == 0) add_blanks();
        case ($urandom_range(0, 2))
            0:       add_number();
            1:       add_variable();
            default: text_q.push_back(CH_LPAR);
        endcase
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 2) == 0) add_blanks();
            case ($urandom_range(0, 5))
                0:       add_number();
                1:       add_variable();
                2, 3:    text_q.push_back(rand_sign_char());
                4: begin
                    text_q.push_back(CH_COLON);
                    text_q.push_back(CH_EQ);
                end
                default: add_blanks();
            endcase
        end
        text_q.push_back($urandom_range(0, 1) ? CH_NL : CH_NUL);
        if ($urandom_range(0, 4) == 0) begin
            idx = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 2))
                0:       text_q[idx] = 8'($urandom_range(0, 255));
                1:       text_q.insert(idx, CH_COLON);
                default: void'(text_q.pop_back());
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every sign, := , leading zeros, an all-zero number, blanks, the bad
    // first token cases, lone colon, untokenizable byte, both terminators.
    task automatic test_directed_tokens();
        send_text("(07-$aZ9)*0/5%1+ :=\t00");
        send_char(CH_NUL);
        send_text(" +");
        send_char(CH_NL);
        send_char(CH_NUL);
        send_text("1:x");
        send_text("$q");
        send_char(8'hFF);
        drain_tokens();
    endtask

    // Expressions that reach the length limit: a terminator right at the
    // limit still ends normally, any other byte there gives too long.
    task automatic test_length_limit();
        send_char(CH_ZERO + 8'd7);
        repeat (MAX_LEN - 1) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        send_char(CH_NL);
        send_char(CH_DOLLAR);
        repeat (MAX_LEN - 1) send_char(rand_alnum());
        send_char(rand_alnum());
        send_text("5\n");
        drain_tokens();
    endtask

    task automatic test_random_expressions();
        int unsigned sent;
        int unsigned exprs;
        sent  = 0;
        exprs = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= QUIET_TAIL) begin
                // full-rate tail: no gaps, no back-pressure
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end else begin
                idle_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            build_expression();
            foreach (text_q[i]) begin
                send_char(text_q[i]);
                if (text_q[i] != CH_SPACE && text_q[i] != CH_TAB) sent++;
            end
            exprs++;
            if (exprs % 60 == 0 && sent < QUIET_TAIL) drain_tokens();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_character = 8'h00;
        restart_expression();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_tokens();
        test_length_limit();
        test_random_expressions();

        drain_tokens();
        // catch any stray token
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("TIMEOUT: %0d tokens still owed", pending_tokens.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/elx_pkg.sv
rtl/elx_step.sv
rtl/elx_fifo.sv
rtl/expression_lexer_core.sv
tb/testbench.sv
